FILE: rtl/x86mov_pkg.sv
`timescale 1ns / 1ps
package x86mov_pkg;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_MODRM   = 3'd1,
    PH_DISP_LO = 3'd2,
    PH_DISP_HI = 3'd3,
    PH_IMM_LO  = 3'd4,
    PH_IMM_HI  = 3'd5,
    PH_ADDR_LO = 3'd6,
    PH_ADDR_HI = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    F_RMREG   = 3'd0,
    F_IMMREG  = 3'd1,
    F_IMMRM   = 3'd2,
    F_ACC2MEM = 3'd3,
    F_MEM2ACC = 3'd4,
    F_UNKNOWN = 3'd5
  } form_t;

  localparam logic [7:0] MASK_RMREG  = 8'b1111_1100;
  localparam logic [7:0] CODE_RMREG  = 8'b1000_1000;
  localparam logic [7:0] MASK_IMMREG = 8'b1111_0000;
  localparam logic [7:0] CODE_IMMREG = 8'b1011_0000;
  localparam logic [7:0] MASK_PAIR   = 8'b1111_1110;
  localparam logic [7:0] CODE_IMMRM  = 8'b1100_0110;
  localparam logic [7:0] CODE_ACC2M  = 8'b1010_0010;
  localparam logic [7:0] CODE_M2ACC  = 8'b1010_0000;
  localparam logic [2:0] RM_DIRECT   = 3'h6;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  opcode_hold;
    logic [7:0]  modrm_hold;
    logic [15:0] disp_hold;
    logic [15:0] imm_hold;
    logic [15:0] addr_hold;
    logic [2:0]  byte_count;
  } dec_state_t;

  typedef struct packed {
    form_t       form;
    logic        wide;
    logic        reg_is_dest;
    logic [2:0]  reg_field;
    logic [1:0]  mode_field;
    logic [2:0]  rm_field;
    logic        direct_mode;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [15:0] direct_address;
    logic [2:0]  length;
  } dec_rec_t;

  function automatic form_t classify(input logic [7:0] op);
    form_t f;
    f = F_UNKNOWN;
    if ((op & MASK_RMREG) == CODE_RMREG) f = F_RMREG;
    else if ((op & MASK_IMMREG) == CODE_IMMREG) f = F_IMMREG;
    else if ((op & MASK_PAIR) == CODE_IMMRM) f = F_IMMRM;
    else if ((op & MASK_PAIR) == CODE_ACC2M) f = F_ACC2MEM;
    else if ((op & MASK_PAIR) == CODE_M2ACC) f = F_MEM2ACC;
    return f;
  endfunction

  function automatic logic op_wide(input logic [7:0] op);
    return (classify(op) == F_IMMREG) ? op[3] : op[0];
  endfunction

endpackage

FILE: rtl/x86_16_mov_instruction_decoder_unit.sv
`timescale 1ns / 1ps
// Decodes 16-bit x86 MOV instructions from a byte stream, one code byte per cycle with no
// bubbles. Each accepted byte passes through a single registered decode step; the
// record for an instruction appears on the output in the cycle after its last byte is
// accepted (every unrecognised opcode byte yields a one-byte unknown record). The
// input stalls only while a finished record sits in the output register and the
// receiver stalls it; a record being taken in the same cycle frees the register.
module x86_16_mov_instruction_decoder_unit import x86mov_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         code_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         form,
  output logic               wide,
  output logic               reg_is_dest,
  output logic [2:0]         reg_field,
  output logic [1:0]         mode_field,
  output logic [2:0]         rm_field,
  output logic               direct_mode,
  output logic signed [15:0] displacement,
  output logic [15:0]        immediate,
  output logic [15:0]        direct_address,
  output logic [2:0]         length
);

  dec_state_t state;
  dec_state_t state_next;
  dec_rec_t   rec_next;
  dec_rec_t   rec;
  logic       emit;
  logic       in_accept;

  x86mov_step u_step (
    .cur       (state),
    .code_byte (code_byte),
    .nxt       (state_next),
    .emit      (emit),
    .rec       (rec_next)
  );

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) state <= state_next;
      if (in_accept && emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (in_accept && emit) rec <= rec_next;
  end

  assign form           = rec.form;
  assign wide           = rec.wide;
  assign reg_is_dest    = rec.reg_is_dest;
  assign reg_field      = rec.reg_field;
  assign mode_field     = rec.mode_field;
  assign rm_field       = rec.rm_field;
  assign direct_mode    = rec.direct_mode;
  assign displacement   = rec.displacement;
  assign immediate      = rec.immediate;
  assign direct_address = rec.direct_address;
  assign length         = rec.length;

  a_new_record_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept && emit))
    else $error("record appeared without an accepted final byte");

  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rec.form == F_UNKNOWN) |-> (rec.length == 3'd1))
    else $error("unknown record with length other than one");

  a_known_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rec.form != F_UNKNOWN) |-> (rec.length >= 3'd2))
    else $error("MOV record shorter than two bytes");

  a_emit_resets_phase: assert property (@(posedge clk) disable iff (rst)
    (in_accept && emit) |=> (state.phase == PH_OPCODE))
    else $error("decoder not back at opcode after a record");

endmodule

FILE: rtl/x86mov_step.sv
`timescale 1ns / 1ps
module x86mov_step import x86mov_pkg::*; (
  input  dec_state_t  cur,
  input  logic [7:0]  code_byte,
  output dec_state_t  nxt,
  output logic        emit,
  output dec_rec_t    rec
);

  form_t      op_form;
  form_t      rf;
  logic [1:0] cur_mod;
  logic [1:0] mod;
  logic [2:0] rm;
  logic       has_modrm;
  logic       is_direct;

  assign op_form = classify(cur.opcode_hold);
  assign cur_mod = cur.modrm_hold[7:6];

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    if (cur.phase == PH_OPCODE) begin
      nxt.opcode_hold = code_byte;
      nxt.modrm_hold  = '0;
      nxt.disp_hold   = '0;
      nxt.imm_hold    = '0;
      nxt.addr_hold   = '0;
      nxt.byte_count  = 3'd1;
      unique case (classify(code_byte))
        F_RMREG, F_IMMRM:     nxt.phase = PH_MODRM;
        F_IMMREG:             nxt.phase = PH_IMM_LO;
        F_ACC2MEM, F_MEM2ACC: nxt.phase = PH_ADDR_LO;
        default:              emit = 1'b1;
      endcase
    end else begin
      nxt.byte_count = cur.byte_count + 3'd1;
      unique case (cur.phase)
        PH_MODRM: begin
          nxt.modrm_hold = code_byte;
          if (code_byte[7:6] == 2'd0 && code_byte[2:0] == RM_DIRECT) begin
            nxt.phase = PH_ADDR_LO;
          end else if (code_byte[7:6] == 2'd1 || code_byte[7:6] == 2'd2) begin
            nxt.phase = PH_DISP_LO;
          end else if (op_form == F_IMMRM) begin
            nxt.phase = PH_IMM_LO;
          end else begin
            emit = 1'b1;
          end
        end
        PH_DISP_LO: begin
          if (cur_mod == 2'd2) begin
            nxt.disp_hold = {8'h00, code_byte};
            nxt.phase     = PH_DISP_HI;
          end else begin
            nxt.disp_hold = {{8{code_byte[7]}}, code_byte};
            if (op_form == F_IMMRM) nxt.phase = PH_IMM_LO;
            else emit = 1'b1;
          end
        end
        PH_DISP_HI: begin
          nxt.disp_hold[15:8] = code_byte;
          if (op_form == F_IMMRM) nxt.phase = PH_IMM_LO;
          else emit = 1'b1;
        end
        PH_ADDR_LO: begin
          nxt.addr_hold = {8'h00, code_byte};
          nxt.phase     = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          nxt.addr_hold[15:8] = code_byte;
          if (op_form == F_IMMRM) nxt.phase = PH_IMM_LO;
          else emit = 1'b1;
        end
        PH_IMM_LO: begin
          nxt.imm_hold = {8'h00, code_byte};
          if (op_wide(cur.opcode_hold)) nxt.phase = PH_IMM_HI;
          else emit = 1'b1;
        end
        PH_IMM_HI: begin
          nxt.imm_hold[15:8] = code_byte;
          emit = 1'b1;
        end
        default: nxt.phase = PH_OPCODE;
      endcase
    end
    if (emit) nxt.phase = PH_OPCODE;
  end

  assign rf        = classify(nxt.opcode_hold);
  assign mod       = nxt.modrm_hold[7:6];
  assign rm        = nxt.modrm_hold[2:0];
  assign has_modrm = (rf == F_RMREG) || (rf == F_IMMRM);
  assign is_direct = (mod == 2'd0) && (rm == RM_DIRECT);

  always_comb begin
    rec        = '0;
    rec.form   = rf;
    rec.length = nxt.byte_count;
    if (rf == F_UNKNOWN) begin
      rec.length = 3'd1;
    end else begin
      rec.wide        = op_wide(nxt.opcode_hold);
      rec.reg_is_dest = ((rf == F_RMREG) && nxt.opcode_hold[1]) ||
                        (rf == F_IMMREG) || (rf == F_MEM2ACC);
      if (has_modrm) begin
        rec.reg_field   = nxt.modrm_hold[5:3];
        rec.mode_field  = mod;
        rec.rm_field    = rm;
        rec.direct_mode = is_direct;
        if (mod == 2'd1 || mod == 2'd2) rec.displacement = nxt.disp_hold;
        if (is_direct) rec.direct_address = nxt.addr_hold;
      end else if (rf == F_IMMREG) begin
        rec.reg_field = nxt.opcode_hold[2:0];
      end
      if (rf == F_IMMREG || rf == F_IMMRM) rec.immediate = nxt.imm_hold;
      if (rf == F_ACC2MEM || rf == F_MEM2ACC) rec.direct_address = nxt.addr_hold;
    end
  end

endmodule
